// ----- hdl/amdea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdea_pkg
// Shared types, codes, the opcode-to-mode decode and the length table for the
// addressing-mode decode and effective-address block.
// ----------------------------------------------------------------------------
package amdea_pkg;

  // Addressing modes
  typedef enum logic [3:0] {
    AM_IMPL   = 4'd0,
    AM_ACC    = 4'd1,
    AM_IMM    = 4'd2,
    AM_ZP     = 4'd3,
    AM_ZPX    = 4'd4,
    AM_ZPY    = 4'd5,
    AM_ABS    = 4'd6,
    AM_ABSX   = 4'd7,
    AM_ABSY   = 4'd8,
    AM_ABSIND = 4'd9,
    AM_XIND   = 4'd10,
    AM_INDY   = 4'd11,
    AM_REL    = 4'd12
  } amode_t;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_PTR    = 2'd1;
  localparam logic [1:0] ST_NOPEND = 2'd2;

  // Commands
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_SUPPLY = 1'b1;

  // Opcodes that break the bit-pattern rules
  localparam logic [7:0] OP_JSR    = 8'h20;
  localparam logic [7:0] OP_JMPIND = 8'h6c;
  localparam logic [7:0] OP_STXZY  = 8'h96;
  localparam logic [7:0] OP_LDXZY  = 8'hb6;
  localparam logic [7:0] OP_LDXAY  = 8'hbe;

  // One input beat
  typedef struct packed {
    logic        cmd;
    logic [7:0]  opcode;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] opcode_pc;
    logic [7:0]  pointer_lo;
    logic [7:0]  pointer_hi;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  status;
    amode_t      mode;
    logic [1:0]  insn_length;
    logic [15:0] next_pc;
    logic [15:0] eff_addr;
    logic [15:0] ptr_addr_lo;
    logic [15:0] ptr_addr_hi;
  } result_t;

  // Opcode to addressing mode, keyed on the low five bits
  function automatic amode_t mode_of(input logic [7:0] op);
    amode_t m;
    begin
      m = AM_IMPL;
      case (op[4:0])
        5'h00: m = op[7] ? AM_IMM : ((op == OP_JSR) ? AM_ABS : AM_IMPL);
        5'h10: m = AM_REL;
        5'h01: m = AM_XIND;
        5'h11: m = AM_INDY;
        5'h02: m = AM_IMM;
        5'h04, 5'h05, 5'h06: m = AM_ZP;
        5'h14, 5'h15, 5'h16:
          m = ((op == OP_STXZY) || (op == OP_LDXZY)) ? AM_ZPY : AM_ZPX;
        5'h08, 5'h18: m = AM_IMPL;
        5'h09: m = AM_IMM;
        5'h19: m = AM_ABSY;
        5'h0a, 5'h1a: m = op[7] ? AM_IMPL : AM_ACC;
        5'h0c, 5'h0d, 5'h0e: m = (op == OP_JMPIND) ? AM_ABSIND : AM_ABS;
        5'h1c, 5'h1d, 5'h1e: m = (op == OP_LDXAY) ? AM_ABSY : AM_ABSX;
        default: m = AM_IMPL;
      endcase
      return m;
    end
  endfunction

  // Instruction length in bytes
  function automatic logic [1:0] length_of(input amode_t m);
    logic [1:0] len;
    begin
      case (m)
        AM_IMPL, AM_ACC: len = 2'd1;
        AM_ABS, AM_ABSX, AM_ABSY, AM_ABSIND: len = 2'd3;
        default: len = 2'd2;
      endcase
      return len;
    end
  endfunction

endpackage

// ----- hdl/amdea_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdea_in_reg
// Input register stage: captures one beat and holds it until the result
// stage takes it.
// ----------------------------------------------------------------------------
module amdea_in_reg
  import amdea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t beat_in,
  input  logic     advance,
  output logic     s1_valid,
  output in_beat_t s1_beat
);

  logic     valid_r, valid_nxt;
  in_beat_t beat_r;
  logic     load;

  // Full and result side blocked: hold off the sender
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_in;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

// ----- hdl/amdea_ea_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdea_ea_core
// Mode decode, length, next PC and effective address for one beat, plus the
// pending indirect request that links a decode to its pointer supply.
// ----------------------------------------------------------------------------
module amdea_ea_core
  import amdea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_beat_t beat,
  output result_t  res
);

  logic       pend_valid_r, pend_valid_nxt;
  amode_t     pend_mode_r, pend_mode_nxt;
  logic [7:0] pend_y_r, pend_y_nxt;

  amode_t      m;
  logic [1:0]  len;
  logic [15:0] word;
  logic [7:0]  zp_x, zp_y, zp_ind;
  logic [15:0] ptr;

  assign m      = mode_of(beat.opcode);
  assign len    = length_of(m);
  assign word   = {beat.operand_hi, beat.operand_lo};
  assign zp_x   = beat.operand_lo + beat.index_x;
  assign zp_y   = beat.operand_lo + beat.index_y;
  assign zp_ind = zp_x + 8'd1;
  assign ptr    = {beat.pointer_hi, beat.pointer_lo};

  // Result and next pending state
  always_comb begin
    res            = '0;
    res.mode       = AM_IMPL;
    pend_valid_nxt = pend_valid_r;
    pend_mode_nxt  = pend_mode_r;
    pend_y_nxt     = pend_y_r;
    if (beat.cmd == CMD_SUPPLY) begin
      if (pend_valid_r) begin
        res.mode       = pend_mode_r;
        res.eff_addr   = (pend_mode_r == AM_INDY) ? ptr + {8'h00, pend_y_r} : ptr;
        pend_valid_nxt = 1'b0;
      end else begin
        res.status = ST_NOPEND;
      end
    end else begin
      res.mode        = m;
      res.insn_length = len;
      res.next_pc     = beat.opcode_pc + {14'd0, len};
      pend_valid_nxt  = 1'b0;
      case (m)
        AM_ZP:   res.eff_addr = {8'h00, beat.operand_lo};
        AM_ZPX:  res.eff_addr = {8'h00, zp_x};
        AM_ZPY:  res.eff_addr = {8'h00, zp_y};
        AM_ABS:  res.eff_addr = word;
        AM_ABSX: res.eff_addr = word + {8'h00, beat.index_x};
        AM_ABSY: res.eff_addr = word + {8'h00, beat.index_y};
        // branch target from the following instruction, signed offset
        AM_REL:  res.eff_addr = beat.opcode_pc + 16'd2
                              + {{8{beat.operand_lo[7]}}, beat.operand_lo};
        // JMP indirect: high byte read stays in the pointer's page
        AM_ABSIND: begin
          res.status      = ST_PTR;
          res.ptr_addr_lo = word;
          res.ptr_addr_hi = {beat.operand_hi, beat.operand_lo + 8'd1};
        end
        AM_XIND: begin
          res.status      = ST_PTR;
          res.ptr_addr_lo = {8'h00, zp_x};
          res.ptr_addr_hi = {8'h00, zp_ind};
        end
        AM_INDY: begin
          res.status      = ST_PTR;
          res.ptr_addr_lo = {8'h00, beat.operand_lo};
          res.ptr_addr_hi = {8'h00, beat.operand_lo + 8'd1};
        end
        default: res.eff_addr = '0;
      endcase
      if (res.status == ST_PTR) begin
        pend_valid_nxt = 1'b1;
        pend_mode_nxt  = m;
        pend_y_nxt     = beat.index_y;
      end
    end
  end

  // Pending request, updated only as a beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_mode_r  <= AM_IMPL;
      pend_y_r     <= 8'h00;
    end else if (fire) begin
      pend_valid_r <= pend_valid_nxt;
      pend_mode_r  <= pend_mode_nxt;
      pend_y_r     <= pend_y_nxt;
    end
  end

  // A pointer request always leaves a pending entry behind
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.status == ST_PTR) |=> pend_valid_r)
    else $error("pointer request did not set pending state");

  // A supply always consumes the pending entry
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && (beat.cmd == CMD_SUPPLY) |=> !pend_valid_r)
    else $error("supply left a pending request");

  // Pending entry only ever holds an indirect mode
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_mode_r == AM_ABSIND) || (pend_mode_r == AM_XIND)
                     || (pend_mode_r == AM_INDY))
    else $error("pending request holds a non-indirect mode");

  // Nothing pending: supply reports no address
  assert property (@(posedge clk) disable iff (!rst_n)
    (beat.cmd == CMD_SUPPLY) && !pend_valid_r |-> (res.eff_addr == 16'h0000)
                                                 && (res.status == ST_NOPEND))
    else $error("supply without request produced an address");

endmodule

// ----- hdl/addressing_mode_decode_and_ea.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressing_mode_decode_and_ea
// Addressing-mode decoder and effective-address unit for a 6502-style CPU.
//
// Input channel (in_*): one beat is either a decode (cmd 0: opcode, operands,
// X, Y and the opcode's PC) or a pointer supply (cmd 1: the two bytes read at
// the pointer addresses a previous indirect decode reported).
// Result channel (out_*): one beat per input beat, in order: status, mode,
// length, next PC, effective address and the pointer addresses.
// An indirect decode answers with status 1; the next supply beat completes
// it. Any other decode drops a pending request.
// An accepted input beat is loaded into the input register; the result
// register then loads from it once free or draining, and out_valid rises.
// Throughput: one beat per cycle while out_stall is low, set by the single
// decode/add path between the two registers.
// Reset clears both stage valids and the pending request.
// While out_stall is high a full result register holds; the input register
// still takes one more beat; in_stall rises only once both stages are full.
// ----------------------------------------------------------------------------
module addressing_mode_decode_and_ea
  import amdea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_lo,
  input  logic [7:0]  in_operand_hi,
  input  logic [7:0]  in_index_x,
  input  logic [7:0]  in_index_y,
  input  logic [15:0] in_opcode_pc,
  input  logic [7:0]  in_pointer_lo,
  input  logic [7:0]  in_pointer_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_address_mode,
  output logic [1:0]  out_insn_length,
  output logic [15:0] out_next_pc,
  output logic [15:0] out_effective_address,
  output logic [15:0] out_ptr_addr_lo,
  output logic [15:0] out_ptr_addr_hi
);

  in_beat_t beat_in, s1_beat;
  logic     s1_valid;
  logic     advance, fire;
  result_t  res, res_r;
  logic     out_valid_r, out_valid_nxt;

  assign beat_in = '{cmd: in_cmd, opcode: in_opcode, operand_lo: in_operand_lo,
                     operand_hi: in_operand_hi, index_x: in_index_x,
                     index_y: in_index_y, opcode_pc: in_opcode_pc,
                     pointer_lo: in_pointer_lo, pointer_hi: in_pointer_hi};

  // Result register free or being drained
  assign advance = !out_valid_r || !out_stall;
  assign fire    = s1_valid && advance;

  amdea_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .beat_in  (beat_in),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  amdea_ea_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (s1_beat),
    .res   (res)
  );

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_r.status;
  assign out_address_mode      = res_r.mode;
  assign out_insn_length       = res_r.insn_length;
  assign out_next_pc           = res_r.next_pc;
  assign out_effective_address = res_r.eff_addr;
  assign out_ptr_addr_lo       = res_r.ptr_addr_lo;
  assign out_ptr_addr_hi       = res_r.ptr_addr_hi;

endmodule
